>>> rtl/sdcd_pkg.sv
// Shared types and constants for the serial date to civil date/time unit.
package sdcd_pkg;

  // Field widths
  localparam int unsigned SerialW = 22;
  localparam int unsigned FracW   = 32;
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  // Register stages from input item to output register
  localparam int unsigned PipeDepth = 12;

  // Calendar and clock constants
  localparam int unsigned EpochJdn  = 2415019;
  localparam int unsigned MarchBase = 1721119;
  localparam int unsigned JdnOffset = EpochJdn - MarchBase;
  localparam int unsigned Days400y  = 146097;
  localparam int unsigned Days4y    = 1461;
  localparam int unsigned Days5mon  = 153;
  localparam int unsigned SecPerDay = 86400;
  localparam int unsigned SecPerMin = 60;

  typedef struct packed {
    logic [SerialW-1:0] serial_day;
    logic [FracW-1:0]   day_fraction;
  } in_t;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day_of_month;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } out_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day_of_month;
  } date_t;

  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } clock_t;

endpackage

>>> rtl/serial_date_to_civil_datetime_unit.sv
// Top level: serial day and day fraction in, Gregorian date and time of day out.
//
// Each item carries a serial day (day 0 is 1899-12-30, Julian day 2415019)
// and a Q0.32 fraction of the day; the result is year, month, day of month
// and the fraction rounded to whole seconds as hour, minute, second. A
// fraction that rounds to a full day gives hour 24 on the same date. The
// unit takes one item per clock while its output is not stalled and offers
// the results in order. The date path has twelve register stages: the day
// offset, three reciprocal-multiply divisions (century, year, month) of
// three stages each, the month operand step and the day step; the time
// path is padded to match. The whole pipeline holds while the output
// register keeps an item that is stalled, so stall_o follows stall_i
// whenever valid_o is high.
module serial_date_to_civil_datetime_unit import sdcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  in_t  data_i,
  output logic valid_o,
  input  logic stall_i,
  output out_t data_o
);

  logic                 en;
  logic [PipeDepth-1:0] vld_q;
  date_t                date;
  clock_t               clock;

  // Advance everything unless a finished item is held at the output
  assign en      = !(vld_q[PipeDepth-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[PipeDepth-1];

  // Valid bits travel with the items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], valid_i};
    end
  end

  sdcd_date u_date (
    .clk_i        (clk_i),
    .en_i         (en),
    .serial_day_i (data_i.serial_day),
    .date_o       (date)
  );

  sdcd_time u_time (
    .clk_i          (clk_i),
    .en_i           (en),
    .day_fraction_i (data_i.day_fraction),
    .clock_o        (clock)
  );

  // Output item from the two aligned paths
  always_comb begin
    data_o.year         = date.year;
    data_o.month        = date.month;
    data_o.day_of_month = date.day_of_month;
    data_o.hour         = clock.hour;
    data_o.minute       = clock.minute;
    data_o.second       = clock.second;
  end

endmodule

>>> rtl/sdcd_date.sv
// Date path: serial day to Gregorian year, month and day in twelve register stages.
module sdcd_date import sdcd_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SerialW-1:0] serial_day_i,
  output date_t              date_o
);

  // Quotient estimates use floor(2^k / d); the estimate is low by at most one
  localparam logic [22:0] Offset     = 23'(JdnOffset);
  localparam logic [7:0]  RecipCent  = 8'((2**25) / Days400y);
  localparam logic [17:0] D400       = 18'(Days400y);
  localparam logic [7:0]  RecipYr    = 8'((2**18) / Days4y);
  localparam logic [10:0] D4         = 11'(Days4y);
  localparam logic [3:0]  RecipMon   = 4'((2**11) / Days5mon);
  localparam logic [7:0]  D5         = 8'(Days5mon);
  // x / 5 for x below 1024 as (x * 205) >> 10
  localparam logic [14:0] DivFiveMul = 15'd205;

  logic [22:0] t1;
  logic [24:0] a1_d, a1_q;
  logic [32:0] prod2;
  logic [24:0] a2_q;
  logic [7:0]  q2_d, q2_q;
  logic [25:0] sub3;
  logic [18:0] r3_d, r3_q;
  logic [7:0]  q3_q;
  logic [17:0] r4;
  logic [7:0]  cent4_d, cent4_q;
  logic [17:0] b4_d, b4_q;
  logic [25:0] prod5;
  logic [6:0]  yc5_d, yc5_q;
  logic [17:0] b5_q;
  logic [7:0]  cent5_q;
  logic [17:0] sub6;
  logic [11:0] e6_d, e6_q;
  logic [6:0]  yc6_q;
  logic [7:0]  cent6_q;
  logic [10:0] e7;
  logic [10:0] e7_sum;
  logic [8:0]  dd7_d, dd7_q;
  logic [6:0]  yc7_d, yc7_q;
  logic [7:0]  cent7_q;
  logic [10:0] f8_d, f8_q;
  logic [13:0] y8_d, y8_q;
  logic [14:0] prod9;
  logic [3:0]  m9_d, m9_q;
  logic [10:0] f9_q;
  logic [13:0] y9_q;
  logic [10:0] sub10;
  logic [8:0]  g10_d, g10_q;
  logic [3:0]  m10_q;
  logic [13:0] y10_q;
  logic [7:0]  g11_d, g11_q;
  logic [3:0]  m11_d, m11_q;
  logic [13:0] y11_q;
  logic [14:0] dq12;
  date_t       date_d, date_q;

  // Stage 1: shifted day count, 4t - 1
  always_comb begin
    t1   = {1'b0, serial_day_i} + Offset;
    a1_d = {t1, 2'b00} - 25'd1;
  end

  // Stage 2: century estimate
  always_comb begin
    prod2 = 33'(a1_q) * 33'(RecipCent);
    q2_d  = prod2[32:25];
  end

  // Stage 3: remainder against the estimate
  always_comb begin
    sub3 = 26'(q2_q) * 26'(D400);
    r3_d = 19'(26'(a2_q) - sub3);
  end

  // Stage 4: century correction, start of the year step
  always_comb begin
    if (r3_q >= 19'(D400)) begin
      cent4_d = q3_q + 8'd1;
      r4      = 18'(r3_q - 19'(D400));
    end else begin
      cent4_d = q3_q;
      r4      = r3_q[17:0];
    end
    b4_d = {r4[17:2], 2'b11};
  end

  // Stage 5: year-in-century estimate
  always_comb begin
    prod5 = 26'(b4_q) * 26'(RecipYr);
    yc5_d = prod5[24:18];
  end

  // Stage 6: remainder of the year step
  always_comb begin
    sub6 = 18'(yc5_q) * 18'(D4);
    e6_d = 12'(b5_q - sub6);
  end

  // Stage 7: year correction, day of the March-based year
  always_comb begin
    if (e6_q >= 12'(D4)) begin
      yc7_d = yc6_q + 7'd1;
      e7    = 11'(e6_q - 12'(D4));
    end else begin
      yc7_d = yc6_q;
      e7    = e6_q[10:0];
    end
    e7_sum = e7 + 11'd4;
    dd7_d  = e7_sum[10:2];
  end

  // Stage 8: month step operand and March-based year
  always_comb begin
    f8_d = 11'(11'(dd7_q) * 11'd5 - 11'd3);
    y8_d = 14'(cent7_q) * 14'd100 + 14'(yc7_q);
  end

  // Stage 9: month estimate
  always_comb begin
    prod9 = 15'(f8_q) * 15'(RecipMon);
    m9_d  = prod9[14:11];
  end

  // Stage 10: remainder of the month step
  always_comb begin
    sub10 = 11'(m9_q) * 11'(D5);
    g10_d = 9'(f9_q - sub10);
  end

  // Stage 11: month correction
  always_comb begin
    if (g10_q >= 9'(D5)) begin
      m11_d = m10_q + 4'd1;
      g11_d = 8'(g10_q - 9'(D5));
    end else begin
      m11_d = m10_q;
      g11_d = g10_q[7:0];
    end
  end

  // Stage 12: day of month, shift the year start from March to January
  always_comb begin
    dq12                = 15'(g11_q) * DivFiveMul;
    date_d.day_of_month = dq12[14:10] + 5'd1;
    if (m11_q < 4'd10) begin
      date_d.month = m11_q + 4'd3;
      date_d.year  = y11_q;
    end else begin
      date_d.month = m11_q - 4'd9;
      date_d.year  = y11_q + 14'd1;
    end
  end

  // Pipeline registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a1_d;
      a2_q    <= a1_q;
      q2_q    <= q2_d;
      r3_q    <= r3_d;
      q3_q    <= q2_q;
      cent4_q <= cent4_d;
      b4_q    <= b4_d;
      yc5_q   <= yc5_d;
      b5_q    <= b4_q;
      cent5_q <= cent4_q;
      e6_q    <= e6_d;
      yc6_q   <= yc5_q;
      cent6_q <= cent5_q;
      dd7_q   <= dd7_d;
      yc7_q   <= yc7_d;
      cent7_q <= cent6_q;
      f8_q    <= f8_d;
      y8_q    <= y8_d;
      m9_q    <= m9_d;
      f9_q    <= f8_q;
      y9_q    <= y8_q;
      g10_q   <= g10_d;
      m10_q   <= m9_q;
      y10_q   <= y9_q;
      g11_q   <= g11_d;
      m11_q   <= m11_d;
      y11_q   <= y10_q;
      date_q  <= date_d;
    end
  end

  assign date_o = date_q;

endmodule

>>> rtl/sdcd_time.sv
// Time path: rounded seconds of the day split into hour, minute and second.
module sdcd_time import sdcd_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [FracW-1:0] day_fraction_i,
  output clock_t           clock_o
);

  // Stages that compute; the rest is a delay line to line up with the date path
  localparam int unsigned CalcStages = 6;
  localparam int unsigned DlyDepth   = PipeDepth - CalcStages;
  localparam logic [48:0] Half       = 49'(1) << (FracW - 1);
  localparam logic [11:0] RecipMin   = 12'((2**17) / SecPerMin);
  localparam logic [5:0]  RecipHr    = 6'((2**11) / SecPerMin);
  localparam logic [6:0]  Sixty      = 7'(SecPerMin);

  logic [48:0] prod1;
  logic [16:0] s1_d, s1_q;
  logic [28:0] prod2;
  logic [10:0] m2_d, m2_q;
  logic [16:0] s2_q;
  logic [16:0] sub3;
  logic [6:0]  rs3_d, rs3_q;
  logic [10:0] m3_q;
  logic [10:0] mins4_d, mins4_q;
  logic [5:0]  sec4_d, sec4_q;
  logic [16:0] prod5;
  logic [4:0]  h5_d, h5_q;
  logic [10:0] mins5_q;
  logic [5:0]  sec5_q;
  logic [10:0] sub6;
  logic [6:0]  rm6_d, rm6_q;
  logic [4:0]  h6_q;
  logic [5:0]  sec6_q;
  clock_t      clk7_d;
  clock_t      dly_q [DlyDepth];

  // Stage 1: seconds of the day, rounded to nearest with ties up
  always_comb begin
    prod1 = 49'(day_fraction_i) * 49'(SecPerDay) + Half;
    s1_d  = prod1[48:32];
  end

  // Stage 2: minute estimate
  always_comb begin
    prod2 = 29'(s1_q) * 29'(RecipMin);
    m2_d  = prod2[27:17];
  end

  // Stage 3: seconds remainder
  always_comb begin
    sub3  = 17'(m2_q) * 17'(Sixty);
    rs3_d = 7'(s2_q - sub3);
  end

  // Stage 4: minute correction
  always_comb begin
    if (rs3_q >= Sixty) begin
      mins4_d = m3_q + 11'd1;
      sec4_d  = 6'(rs3_q - Sixty);
    end else begin
      mins4_d = m3_q;
      sec4_d  = rs3_q[5:0];
    end
  end

  // Stage 5: hour estimate
  always_comb begin
    prod5 = 17'(mins4_q) * 17'(RecipHr);
    h5_d  = prod5[15:11];
  end

  // Stage 6: minutes remainder
  always_comb begin
    sub6  = 11'(h5_q) * 11'(Sixty);
    rm6_d = 7'(mins5_q - sub6);
  end

  // Hour correction, feeds the delay line
  always_comb begin
    clk7_d.second = sec6_q;
    if (rm6_q >= Sixty) begin
      clk7_d.hour   = h6_q + 5'd1;
      clk7_d.minute = 6'(rm6_q - Sixty);
    end else begin
      clk7_d.hour   = h6_q;
      clk7_d.minute = rm6_q[5:0];
    end
  end

  // Pipeline registers and delay line
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q    <= s1_d;
      m2_q    <= m2_d;
      s2_q    <= s1_q;
      rs3_q   <= rs3_d;
      m3_q    <= m2_q;
      mins4_q <= mins4_d;
      sec4_q  <= sec4_d;
      h5_q    <= h5_d;
      mins5_q <= mins4_q;
      sec5_q  <= sec4_q;
      rm6_q   <= rm6_d;
      h6_q    <= h5_q;
      sec6_q  <= sec5_q;
      dly_q[0] <= clk7_d;
      for (int i = 1; i < DlyDepth; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign clock_o = dly_q[DlyDepth-1];

endmodule

>>> test/sdcd_checker.sv
// Checker for the serial date unit: predicts each civil date/time and compares results.
module sdcd_checker import sdcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  logic        item_stall_i,
  input  in_t         item_i,
  input  logic        result_valid_i,
  input  logic        result_stall_i,
  input  out_t        result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  out_t        awaited_datetimes[$];
  int unsigned mismatches  = 0;
  int unsigned outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // Gregorian date from the serial day, rounded time of day from the fraction
  function automatic out_t civil_datetime_of(in_t item);
    logic [31:0] t;
    logic [31:0] cent;
    logic [31:0] r;
    logic [31:0] dd;
    logic [31:0] yc;
    logic [31:0] m;
    logic [31:0] y;
    logic [63:0] scaled;
    logic [31:0] secs;
    logic [31:0] mins;
    out_t        res;
    // Days since the March-based year zero
    t    = 32'(item.serial_day) + 32'(EpochJdn - MarchBase);
    cent = (4 * t - 1) / Days400y;
    r    = 4 * t - 1 - Days400y * cent;
    dd   = r / 4;
    yc   = (4 * dd + 3) / Days4y;
    dd   = 4 * dd + 3 - Days4y * yc;
    dd   = (dd + 4) / 4;
    m    = (5 * dd - 3) / Days5mon;
    dd   = 5 * dd - 3 - Days5mon * m;
    dd   = (dd + 5) / 5;
    y    = 100 * cent + yc;
    // Shift the March-based month back to January-based
    if (m < 10) begin
      m = m + 3;
    end else begin
      m = m - 9;
      y = y + 1;
    end
    // Round to nearest second, ties upward; a full day stays on the same date
    scaled = 64'(item.day_fraction) * 64'(SecPerDay) + 64'h8000_0000;
    secs   = 32'(scaled >> 32);
    mins   = secs / SecPerMin;
    res.year         = YearW'(y);
    res.month        = MonthW'(m);
    res.day_of_month = DayW'(dd);
    res.hour         = HourW'(mins / SecPerMin);
    res.minute       = MinuteW'(mins % SecPerMin);
    res.second       = SecondW'(secs % SecPerMin);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Queue a prediction per accepted item, check each accepted result in order
  always @(posedge clk_i) begin : track
    out_t want;
    if (rst_ni) begin
      if (item_valid_i && !item_stall_i) begin
        awaited_datetimes.push_back(civil_datetime_of(item_i));
      end
      if (result_valid_i && !result_stall_i) begin
        if (awaited_datetimes.size() == 0) begin
          report_mismatch("unrequested result", 64'(result_i), 64'd0);
        end else begin
          want = awaited_datetimes.pop_front();
          if (result_i.year != want.year) begin
            report_mismatch("year", 64'(result_i.year), 64'(want.year));
          end
          if (result_i.month != want.month) begin
            report_mismatch("month", 64'(result_i.month), 64'(want.month));
          end
          if (result_i.day_of_month != want.day_of_month) begin
            report_mismatch("day_of_month", 64'(result_i.day_of_month),
                            64'(want.day_of_month));
          end
          if (result_i.hour != want.hour) begin
            report_mismatch("hour", 64'(result_i.hour), 64'(want.hour));
          end
          if (result_i.minute != want.minute) begin
            report_mismatch("minute", 64'(result_i.minute), 64'(want.minute));
          end
          if (result_i.second != want.second) begin
            report_mismatch("second", 64'(result_i.second), 64'(want.second));
          end
        end
      end
      outstanding = awaited_datetimes.size();
    end
  end

endmodule

>>> test/testbench.sv
// Top of the serial date unit test: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
  import sdcd_pkg::*;

  localparam int unsigned RandomItems = 1100;
  localparam int unsigned CalmItems   = 150;
  localparam int unsigned PauseAt     = 400;
  localparam int unsigned CycleLimit  = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  in_t         data_i;
  logic        valid_o;
  logic        stall_i;
  out_t        data_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;

  serial_date_to_civil_datetime_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .data_i  (data_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .data_o  (data_o)
  );

  sdcd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (valid_i),
    .item_stall_i   (stall_o),
    .item_i         (data_i),
    .result_valid_i (valid_o),
    .result_stall_i (stall_i),
    .result_i       (data_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[serial_date_to_civil_datetime_unit] ERROR");
      $finish;
    end
  end

  function automatic in_t timestamp(int unsigned serial, logic [31:0] frac);
    in_t item;
    item.serial_day   = SerialW'(serial);
    item.day_fraction = frac;
    return item;
  endfunction

  // Random item, weighted toward calendar and rounding boundaries
  function automatic in_t random_timestamp();
    in_t         item;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      item.serial_day = SerialW'($urandom());
    end else if (pick < 70) begin
      item.serial_day = SerialW'($urandom_range(0, 120000));
    end else if (pick < 85) begin
      // around a turn of the century
      item.serial_day = SerialW'($urandom_range(36500, 36600) + 36524 * $urandom_range(0, 100));
    end else begin
      item.serial_day = SerialW'(32'h003F_FFFF - $urandom_range(0, 2000));
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      item.day_fraction = $urandom();
    end else if (pick < 55) begin
      item.day_fraction = $urandom_range(0, 65535);
    end else if (pick < 70) begin
      item.day_fraction = 32'hFFFF_FFFF - $urandom_range(0, 65535);
    end else if (pick < 85) begin
      // exact half-second ties and their neighbors
      item.day_fraction = {8'(2 * $urandom_range(0, 127) + 1), 24'h0} + $urandom_range(0, 2) - 1;
    end else begin
      // near an arbitrary half-second point
      item.day_fraction = 32'((64'(2 * $urandom_range(0, 86399) + 1) << 31) / 64'(SecPerDay))
                          + $urandom_range(0, 2) - 1;
    end
    return item;
  endfunction

  // Optional idle gap, then present the item and hold it until taken
  task automatic send_item(in_t item, int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    valid_i <= 1'b1;
    data_i  <= item;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Receiver stalls in bursts, stall rate redrawn on every 64th pass of its loop
  initial begin : receiver_stalls
    int unsigned burst;
    int unsigned mode;
    int unsigned tick;
    stall_i = 1'b0;
    mode    = 0;
    tick    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      if (!calm && mode != 0 && $urandom_range(0, 9) < mode * 2) begin
        burst = $urandom_range(1, 14);
        stall_i <= 1'b1;
        repeat (burst - 1) @(negedge clk_i);
        @(negedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    in_t         directed[$];
    int unsigned k;
    int unsigned mode;
    int unsigned gap;
    rst_ni  = 1'b0;
    valid_i = 1'b0;
    data_i  = '0;
    mode    = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // epoch, midnight, and both input extremes (full day by rounding)
    directed.push_back(timestamp(0, 32'h0000_0000));
    directed.push_back(timestamp(32'h003F_FFFF, 32'hFFFF_FFFF));
    directed.push_back(timestamp(32'h003F_FFFE, 32'h0000_0001));
    // last fraction giving 23:59:59, first giving hour 24
    directed.push_back(timestamp(0, 32'd4294942440));
    directed.push_back(timestamp(0, 32'd4294942441));
    // exact half-second tie rounds up, one below it rounds down
    directed.push_back(timestamp(1, 32'h0100_0000));
    directed.push_back(timestamp(1, 32'h00FF_FFFF));
    directed.push_back(timestamp(1, 32'h8000_0000));
    // end of February in 1900, which is not a leap year
    directed.push_back(timestamp(59, 32'h4000_0000));
    directed.push_back(timestamp(60, 32'hC000_0000));
    directed.push_back(timestamp(61, 32'h0000_0000));
    // last two days of 1900
    directed.push_back(timestamp(365, 32'h1234_5678));
    directed.push_back(timestamp(366, 32'h8765_4321));
    // last two days of 1999 and the leap day of 2000
    directed.push_back(timestamp(36524, 32'hFFFF_0000));
    directed.push_back(timestamp(36525, 32'h0000_FFFF));
    directed.push_back(timestamp(36583, 32'h2000_0000));
    directed.push_back(timestamp(36584, 32'h6000_0000));
    directed.push_back(timestamp(36585, 32'hA000_0000));
    // alternating bit patterns
    directed.push_back(timestamp(32'h002A_AAAA, 32'h5555_5555));
    directed.push_back(timestamp(32'h0015_5555, 32'hAAAA_AAAA));

    foreach (directed[i]) begin
      send_item(directed[i], ($urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0);
    end

    for (k = 0; k < RandomItems; k++) begin
      if (k == RandomItems - CalmItems) calm = 1'b1;
      if (k == PauseAt) drain_results();
      if (k % 64 == 0) mode = $urandom_range(0, 3);
      gap = (!calm && mode != 0 && $urandom_range(0, 9) < mode * 2) ? $urandom_range(1, 14) : 0;
      send_item(random_timestamp(), gap);
    end

    drain_results();
    repeat (2 * PipeDepth) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[serial_date_to_civil_datetime_unit] OK");
    end else begin
      $display("[serial_date_to_civil_datetime_unit] ERROR");
    end
    $finish;
  end

endmodule
